/* src/slt_pkg.sv */
package slt_pkg;

    localparam int OP_W   = 2;
    localparam int SLOT_W = 6;
    localparam int LEN_W  = 7;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_FREE,
        ST_WALK,
        ST_EVAL,
        ST_WRITE_A,
        ST_WRITE_B,
        ST_RESP
    } t_state;

    // read address source for the slot RAMs
    typedef enum logic [1:0] {
        RD_FREE,
        RD_HEAD,
        RD_NEXT
    } t_rd_sel;

    typedef enum logic [2:0] {
        UPD_NONE,
        UPD_INS_NODE,
        UPD_INS_LINK,
        UPD_DEL_LINK,
        UPD_DEL_FREE,
        UPD_CLEAR
    } t_upd;

    typedef enum logic [1:0] {
        RES_KEEP,
        RES_FAIL,
        RES_DONE,
        RES_SEARCH
    } t_res;

    typedef struct packed {
        logic    load;
        logic    free_cap;
        logic    walk_start;
        logic    walk_step;
        t_rd_sel rd_sel;
        t_upd    upd;
        t_res    res;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic free_empty;
        logic list_empty;
        logic walk_done;
        logic found;
        logic out_free;
    } t_dp_stat;

endpackage

/* src/slt_in_if.sv */
interface slt_in_if import slt_pkg::*; #(
    parameter int KEY_BITS = 32
);
    logic                       valid;
    logic                       ready;
    logic [OP_W-1:0]            opcode;
    logic signed [KEY_BITS-1:0] key;

    modport source (output valid, output opcode, output key, input ready);
    modport sink   (input valid, input opcode, input key, output ready);
endinterface

/* src/slt_out_if.sv */
interface slt_out_if import slt_pkg::*;;
    logic              valid;
    logic              ready;
    logic              success;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  length;

    modport source (output valid, output success, output slot, output length, input ready);
    modport sink   (input valid, input success, input slot, input length, output ready);
endinterface

/* src/slt_ram.sv */
module slt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* src/slt_ctrl.sv */
module slt_ctrl import slt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);
    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.rd_sel = RD_NEXT;
        o_in_ready   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (i_stat.op)
                    OP_CLEAR: begin
                        o_cmd.upd = UPD_CLEAR;
                        o_cmd.res = RES_DONE;
                        n_state   = ST_RESP;
                    end
                    OP_INSERT: begin
                        if (i_stat.free_empty) begin
                            o_cmd.res = RES_FAIL;
                            n_state   = ST_RESP;
                        end else begin
                            // fetch the link of the free-list head first
                            o_cmd.rd_sel = RD_FREE;
                            n_state      = ST_FREE;
                        end
                    end
                    default: begin
                        o_cmd.walk_start = 1'b1;
                        o_cmd.rd_sel     = RD_HEAD;
                        n_state          = i_stat.list_empty ? ST_EVAL : ST_WALK;
                    end
                endcase
            end
            ST_FREE: begin
                o_cmd.free_cap   = 1'b1;
                o_cmd.walk_start = 1'b1;
                o_cmd.rd_sel     = RD_HEAD;
                n_state          = i_stat.list_empty ? ST_EVAL : ST_WALK;
            end
            ST_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_stat.walk_done) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                case (i_stat.op)
                    OP_INSERT: begin
                        if (i_stat.found) begin
                            o_cmd.res = RES_FAIL;
                            n_state   = ST_RESP;
                        end else begin
                            n_state = ST_WRITE_A;
                        end
                    end
                    OP_DELETE: begin
                        if (!i_stat.found) begin
                            o_cmd.res = RES_FAIL;
                            n_state   = ST_RESP;
                        end else begin
                            n_state = ST_WRITE_A;
                        end
                    end
                    default: begin
                        o_cmd.res = RES_SEARCH;
                        n_state   = ST_RESP;
                    end
                endcase
            end
            ST_WRITE_A: begin
                o_cmd.upd = (i_stat.op == OP_INSERT) ? UPD_INS_NODE : UPD_DEL_LINK;
                n_state   = ST_WRITE_B;
            end
            ST_WRITE_B: begin
                o_cmd.upd = (i_stat.op == OP_INSERT) ? UPD_INS_LINK : UPD_DEL_FREE;
                o_cmd.res = RES_DONE;
                n_state   = ST_RESP;
            end
            ST_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end
endmodule

/* src/slt_dpath.sv */
module slt_dpath import slt_pkg::*; #(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dp_cmd                    i_cmd,
    output t_dp_stat                   o_stat,
    input  logic [OP_W-1:0]            i_opcode,
    input  logic signed [KEY_BITS-1:0] i_key,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_success,
    output logic [SLOT_W-1:0]          o_slot,
    output logic [LEN_W-1:0]           o_length
);
    localparam int IDX_W = $clog2(CAPACITY + 1);
    localparam int AW    = $clog2(CAPACITY);
    localparam logic [IDX_W-1:0] END_MARK  = IDX_W'(CAPACITY);
    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(CAPACITY - 1);

    // list state
    logic [IDX_W-1:0] r_list_head;
    logic [IDX_W-1:0] r_free_head;
    logic [IDX_W-1:0] r_fresh;      // slots at and above this were never linked
    logic [IDX_W-1:0] r_count;

    // per-operation working registers
    t_op                        r_op;
    logic signed [KEY_BITS-1:0] r_key;
    logic [IDX_W-1:0]           r_i;
    logic [IDX_W-1:0]           r_prev;
    logic [IDX_W-1:0]           r_next;
    logic [IDX_W-1:0]           r_steps;
    logic [IDX_W-1:0]           r_free_next;
    logic                       r_found;
    logic                       r_ok;
    logic [IDX_W-1:0]           r_slot;

    // output word
    logic              r_out_valid;
    logic              r_out_success;
    logic [SLOT_W-1:0] r_out_slot;
    logic [LEN_W-1:0]  r_out_length;

    logic [AW-1:0]       rd_addr;
    logic [KEY_BITS-1:0] key_rdata;
    logic [IDX_W-1:0]    link_rdata;
    logic [IDX_W-1:0]    link_nxt;
    logic                key_we;
    logic                link_we;
    logic [AW-1:0]       link_waddr;
    logic [IDX_W-1:0]    link_wdata;
    logic                less;
    logic                step_last;
    logic                walk_done;

    logic [SLOT_W+IDX_W-1:0] slot_ext;
    logic [LEN_W+IDX_W-1:0]  len_ext;

    slt_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (r_free_head[AW-1:0]),
        .i_wdata (r_key),
        .i_raddr (rd_addr),
        .o_rdata (key_rdata)
    );

    slt_ram #(
        .WIDTH (IDX_W),
        .DEPTH (CAPACITY)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (rd_addr),
        .o_rdata (link_rdata)
    );

    assign link_nxt  = (link_rdata >= END_MARK) ? END_MARK : link_rdata;
    assign less      = $signed(key_rdata) < r_key;
    assign step_last = (r_steps == LAST_STEP);
    assign walk_done = !less || (link_nxt == END_MARK) || step_last;

    // the next address comes straight off the link read, one slot per cycle
    always_comb begin
        case (i_cmd.rd_sel)
            RD_FREE: rd_addr = r_free_head[AW-1:0];
            RD_HEAD: rd_addr = r_list_head[AW-1:0];
            default: rd_addr = link_nxt[AW-1:0];
        endcase
    end

    always_comb begin
        key_we     = 1'b0;
        link_we    = 1'b0;
        link_waddr = r_prev[AW-1:0];
        link_wdata = r_free_head;
        case (i_cmd.upd)
            UPD_INS_NODE: begin
                key_we     = 1'b1;
                link_we    = 1'b1;
                link_waddr = r_free_head[AW-1:0];
                link_wdata = r_i;
            end
            UPD_INS_LINK: begin
                link_we = (r_prev != END_MARK);
            end
            UPD_DEL_LINK: begin
                link_we    = (r_prev != END_MARK);
                link_wdata = r_next;
            end
            UPD_DEL_FREE: begin
                link_we    = 1'b1;
                link_waddr = r_i[AW-1:0];
            end
            default: begin
                link_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_list_head <= END_MARK;
            r_free_head <= '0;
            r_fresh     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (i_cmd.upd)
                UPD_INS_LINK: begin
                    if (r_prev == END_MARK) begin
                        r_list_head <= r_free_head;
                    end
                    r_free_head <= r_free_next;
                    if (r_free_head >= r_fresh) begin
                        r_fresh <= IDX_W'(r_free_head + 1'b1);
                    end
                    r_count <= IDX_W'(r_count + 1'b1);
                end
                UPD_DEL_LINK: begin
                    if (r_prev == END_MARK) begin
                        r_list_head <= r_next;
                    end
                end
                UPD_DEL_FREE: begin
                    r_free_head <= r_i;
                    if (r_count != '0) begin
                        r_count <= IDX_W'(r_count - 1'b1);
                    end
                end
                UPD_CLEAR: begin
                    r_list_head <= END_MARK;
                    r_free_head <= '0;
                    r_fresh     <= '0;
                    r_count     <= '0;
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign slot_ext = {{SLOT_W{1'b0}}, r_slot};
    assign len_ext  = {{LEN_W{1'b0}}, r_count};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= t_op'(i_opcode);
            r_key <= i_key;
        end
        if (i_cmd.free_cap) begin
            // untouched slots still chain to the next index
            r_free_next <= (r_free_head >= r_fresh) ? IDX_W'(r_free_head + 1'b1) : link_nxt;
        end
        if (i_cmd.walk_start) begin
            r_i     <= r_list_head;
            r_prev  <= END_MARK;
            r_steps <= '0;
            r_found <= 1'b0;
        end else if (i_cmd.walk_step) begin
            if (less) begin
                r_prev  <= r_i;
                r_i     <= step_last ? END_MARK : link_nxt;
                r_steps <= IDX_W'(r_steps + 1'b1);
            end else begin
                r_found <= ($signed(key_rdata) == r_key);
                r_next  <= link_nxt;
            end
        end
        case (i_cmd.res)
            RES_FAIL: begin
                r_ok   <= 1'b0;
                r_slot <= '0;
            end
            RES_DONE: begin
                r_ok   <= 1'b1;
                r_slot <= '0;
            end
            RES_SEARCH: begin
                r_ok   <= r_found;
                r_slot <= r_found ? r_i : '0;
            end
            default: begin
                r_ok <= r_ok;
            end
        endcase
        if (i_cmd.out_load) begin
            r_out_success <= r_ok;
            r_out_slot    <= slot_ext[SLOT_W-1:0];
            r_out_length  <= len_ext[LEN_W-1:0];
        end
    end

    assign o_stat.op         = r_op;
    assign o_stat.free_empty = (r_free_head == END_MARK);
    assign o_stat.list_empty = (r_list_head == END_MARK);
    assign o_stat.walk_done  = walk_done;
    assign o_stat.found      = r_found;
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_success   = r_out_success;
    assign o_slot      = r_out_slot;
    assign o_length    = r_out_length;
endmodule

/* src/sorted_linked_list_table_core.sv */
// Channel | Dir | Payload                  | Transfer
// i_in    | in  | opcode, key              | valid && ready
// o_out   | out | success, slot, length    | valid && ready
//
// One word in flight: i_in.ready is high only while the controller is idle.
// An operation walks the list through the single RAM read port, one slot per cycle,
// visiting at most CAPACITY slots; a failed delete or insert skips both write states
// (ST_WRITE_A, ST_WRITE_B), and an insert into a full pool skips the walk.
// Reset is synchronous; no RAM sweep is needed since
// never-allocated slots are tracked by a high-water mark.
// A stalled o_out holds its word; the next input word is still taken.
module sorted_linked_list_table_core import slt_pkg::*; #(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    slt_in_if.sink   i_in,
    slt_out_if.source o_out
);
    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     in_ready;

    slt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    slt_dpath #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_opcode    (i_in.opcode),
        .i_key       (i_in.key),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_success   (o_out.success),
        .o_slot      (o_out.slot),
        .o_length    (o_out.length)
    );

    assign i_in.ready = in_ready;
endmodule

/* src/slt_checker.sv */
module slt_checker import slt_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic              i_success,
    input logic [SLOT_W-1:0] i_slot,
    input logic [LEN_W-1:0]  i_length
);
    // one word at a time: taking a word closes the input side
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input taken while a word is in progress");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output word survived reset");

    // a slot index is reported only for a successful search
    a_fail_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_success) |-> (i_slot == '0))
        else $error("failed word carries a slot index");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> $stable({i_success, i_slot, i_length}))
        else $error("output word changed while stalled");
endmodule

bind sorted_linked_list_table_core slt_checker u_slt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_success   (o_out.success),
    .i_slot      (o_out.slot),
    .i_length    (o_out.length)
);
